// ----- rtl/core/rcc_pkg.sv -----
`default_nettype none
package rcc_pkg;

    localparam int DEGREE_BINS_DEF   = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int NODE_W  = 32;
    localparam int ARC_W   = 40;
    localparam int COEF_W  = 17;
    localparam int OP_W    = 3;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 112;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_NODE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ARC   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    localparam logic KIND_FIN   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/core/rich_club_coefficient_engine_core.sv -----
`default_nettype none
// Rich-club coefficient engine.
// Input channel (s_axis): tuser carries the opcode (clear, node, arc, finalize,
// query); tdata carries the item fields. Output channel (m_axis): tuser is the
// result kind, tdata the summary or query answer. Only finalize and query
// items give a result.
// Both histograms live in single-port-read, single-port-write memories of
// DEGREE_BINS entries with a registered read.
// Node and arc items read their bin, then write back the incremented bin.
// Finalize runs the top-down suffix-sum sweep that reads and rewrites one bin
// per cycle; a repeated finalize skips the sweep. A query for a club under
// two nodes skips the divider; otherwise the bit-per-cycle coefficient
// divider forms the ratio, saturating it outright when there are two or more
// arcs per node pair.
// Reset and a clear item both start a clearing pass that zeroes every bin; no
// item is accepted during it.
// One output register holds a result. While it waits on a stalled receiver,
// node and arc items are still taken; a finalize or query holds in its last
// step until the register frees up.
module rich_club_coefficient_engine_core #(
    parameter int DEGREE_BINS   = rcc_pkg::DEGREE_BINS_DEF,
    parameter int FRACTION_BITS = rcc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // in_arcs[15:0], out_arcs[31:16], source_degree[48:32],
    // dst_degree[65:49], self_loop[66], threshold[76:67], zero pad
    input  wire logic [rcc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode[2:0]
    input  wire logic [rcc_pkg::OP_W-1:0]        i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // valid_res[0], club_nodes[32:1], club_arc_count[72:33],
    // coefficient_q16[89:73], useful_thresholds[100:90],
    // largest_degree[110:101], overflow[111]
    output logic      [rcc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // kind[0]
    output logic                                 o_m_axis_tuser
);
    import rcc_pkg::*;

    localparam int AW = $clog2(DEGREE_BINS);
    localparam logic [AW-1:0] TOP_A = AW'(DEGREE_BINS - 1);
    localparam logic [16:0]   TOP_D = 17'(DEGREE_BINS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_QRD  = 3'd4;
    localparam logic [2:0] S_QDIV = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // item fields
    logic [OP_W-1:0] in_op;
    logic [15:0]     in_in, in_out;
    logic [16:0]     in_src, in_tgt;
    logic            in_self;
    logic [9:0]      in_th;

    assign in_op   = i_s_axis_tuser;
    assign in_in   = i_s_axis_tdata[15:0];
    assign in_out  = i_s_axis_tdata[31:16];
    assign in_src  = i_s_axis_tdata[48:32];
    assign in_tgt  = i_s_axis_tdata[65:49];
    assign in_self = i_s_axis_tdata[66];
    assign in_th   = i_s_axis_tdata[76:67];

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_is_arc, n_is_arc;
    logic              r_fin, n_fin;
    logic              r_ovf, n_ovf;
    logic [AW-1:0]     r_max, n_max;
    logic [AW:0]       r_useful, n_useful;
    logic [NODE_W-1:0] r_na, n_na;
    logic [ARC_W-1:0]  r_aa, n_aa;
    logic              r_qv, n_qv;
    logic [NODE_W-1:0] r_n, n_n;
    logic [ARC_W-1:0]  r_a, n_a;
    logic              r_kind, n_kind;
    logic [COEF_W-1:0] r_coef, n_coef;
    logic              r_m_tvalid, n_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic              r_m_tuser, n_m_tuser;

    // memory port
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [NODE_W-1:0] rd_node;
    logic [ARC_W-1:0]  rd_arc;
    logic              wr_node_en, wr_arc_en;
    logic [AW-1:0]     wr_addr;
    logic [NODE_W-1:0] wr_node;
    logic [ARC_W-1:0]  wr_arc;

    logic              coef_start, coef_done;
    logic [COEF_W-1:0] coef_val;

    // degree decode, clamped to the top bin
    logic [16:0]   node_sum, arc_min;
    logic          node_clamp, arc_clamp, th_ok, accept;
    logic [AW-1:0] node_d, arc_d;
    logic [NODE_W:0] na_sum;
    logic [ARC_W:0]  aa_sum;

    assign node_sum   = {1'b0, in_in} + {1'b0, in_out};
    assign arc_min    = (in_src < in_tgt) ? in_src : in_tgt;
    assign node_clamp = node_sum > TOP_D;
    assign arc_clamp  = arc_min > TOP_D;
    assign node_d     = node_clamp ? TOP_A : AW'(node_sum);
    assign arc_d      = arc_clamp ? TOP_A : AW'(arc_min);
    assign th_ok      = {7'd0, in_th} <= TOP_D;
    assign na_sum     = {1'b0, r_na} + {1'b0, rd_node};
    assign aa_sum     = {1'b0, r_aa} + {1'b0, rd_arc};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_is_arc   = r_is_arc;
        n_fin      = r_fin;
        n_ovf      = r_ovf;
        n_max      = r_max;
        n_useful   = r_useful;
        n_na       = r_na;
        n_aa       = r_aa;
        n_qv       = r_qv;
        n_n        = r_n;
        n_a        = r_a;
        n_kind     = r_kind;
        n_coef     = r_coef;
        n_m_tvalid = r_m_tvalid && !i_m_axis_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        rd_en      = 1'b0;
        rd_addr    = r_addr;
        wr_node_en = 1'b0;
        wr_arc_en  = 1'b0;
        wr_addr    = r_addr;
        wr_node    = '0;
        wr_arc     = '0;
        coef_start = 1'b0;

        unique case (r_state)
            S_CLR: begin
                wr_node_en = 1'b1;
                wr_arc_en  = 1'b1;
                if (r_addr == TOP_A) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_CLEAR: begin
                            n_state  = S_CLR;
                            n_addr   = '0;
                            n_fin    = 1'b0;
                            n_ovf    = 1'b0;
                            n_max    = '0;
                            n_useful = '0;
                        end
                        OP_NODE: begin
                            if (!r_fin) begin
                                rd_en    = 1'b1;
                                rd_addr  = node_d;
                                n_addr   = node_d;
                                n_is_arc = 1'b0;
                                n_state  = S_RMW;
                                if (node_clamp) begin
                                    n_ovf = 1'b1;
                                end
                                if (node_d > r_max) begin
                                    n_max = node_d;
                                end
                            end
                        end
                        OP_ARC: begin
                            if (!r_fin && !in_self) begin
                                rd_en    = 1'b1;
                                rd_addr  = arc_d;
                                n_addr   = arc_d;
                                n_is_arc = 1'b1;
                                n_state  = S_RMW;
                                if (arc_clamp) begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end
                        OP_FIN: begin
                            n_kind = KIND_FIN;
                            if (r_fin) begin
                                n_state = S_OUT;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = TOP_A;
                                n_addr   = TOP_A;
                                n_na     = '0;
                                n_aa     = '0;
                                n_useful = '0;
                                n_state  = S_FIN;
                            end
                        end
                        OP_QUERY: begin
                            n_kind  = KIND_QUERY;
                            n_qv    = r_fin && th_ok;
                            rd_en   = 1'b1;
                            rd_addr = AW'(in_th);
                            n_state = S_QRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW: begin
                // saturating bin increment
                if (r_is_arc) begin
                    wr_arc_en = 1'b1;
                    if (&rd_arc) begin
                        wr_arc = rd_arc;
                        n_ovf  = 1'b1;
                    end else begin
                        wr_arc = rd_arc + ARC_W'(1);
                    end
                end else begin
                    wr_node_en = 1'b1;
                    if (&rd_node) begin
                        wr_node = rd_node;
                        n_ovf   = 1'b1;
                    end else begin
                        wr_node = rd_node + NODE_W'(1);
                    end
                end
                n_state = S_IDLE;
            end
            S_FIN: begin
                // bin t gets the sum of the bins above it
                wr_node_en = 1'b1;
                wr_arc_en  = 1'b1;
                wr_node    = r_na;
                wr_arc     = r_aa;
                if (na_sum[NODE_W]) begin
                    n_na  = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_na = na_sum[NODE_W-1:0];
                end
                if (aa_sum[ARC_W]) begin
                    n_aa  = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_aa = aa_sum[ARC_W-1:0];
                end
                if (r_na >= NODE_W'(2)) begin
                    n_useful = r_useful + (AW + 1)'(1);
                end
                if (r_addr == '0) begin
                    n_fin   = 1'b1;
                    n_state = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr - AW'(1);
                    n_addr  = r_addr - AW'(1);
                end
            end
            S_QRD: begin
                n_n = r_qv ? rd_node : '0;
                n_a = r_qv ? rd_arc : '0;
                if (r_qv && rd_node >= NODE_W'(2)) begin
                    coef_start = 1'b1;
                    n_state    = S_QDIV;
                end else begin
                    n_coef  = '0;
                    n_state = S_OUT;
                end
            end
            S_QDIV: begin
                if (coef_done) begin
                    n_coef  = coef_val;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_tvalid || i_m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tuser  = r_kind;
                    if (r_kind == KIND_QUERY) begin
                        n_m_tdata = {r_ovf, 10'd0, 11'd0, r_coef, r_a, r_n,
                                     (r_n >= NODE_W'(2))};
                    end else begin
                        n_m_tdata = {r_ovf, 10'(r_max), 11'(r_useful), 17'd0,
                                     40'd0, 32'd0, 1'b0};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_is_arc   <= 1'b0;
            r_fin      <= 1'b0;
            r_ovf      <= 1'b0;
            r_max      <= '0;
            r_useful   <= '0;
            r_qv       <= 1'b0;
            r_kind     <= KIND_FIN;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_is_arc   <= n_is_arc;
            r_fin      <= n_fin;
            r_ovf      <= n_ovf;
            r_max      <= n_max;
            r_useful   <= n_useful;
            r_qv       <= n_qv;
            r_kind     <= n_kind;
            r_m_tvalid <= n_m_tvalid;
        end
        r_na      <= n_na;
        r_aa      <= n_aa;
        r_n       <= n_n;
        r_a       <= n_a;
        r_coef    <= n_coef;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    rcc_bin_mem #(
        .DEPTH (DEGREE_BINS),
        .AW    (AW)
    ) u_bins (
        .i_clk        (i_clk),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_node    (rd_node),
        .o_rd_arc     (rd_arc),
        .i_wr_node_en (wr_node_en),
        .i_wr_arc_en  (wr_arc_en),
        .i_wr_addr    (wr_addr),
        .i_wr_node    (wr_node),
        .i_wr_arc     (wr_arc)
    );

    rcc_coef #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (coef_start),
        .i_n     (rd_node),
        .i_arcs  (rd_arc),
        .o_done  (coef_done),
        .o_coef  (coef_val)
    );

endmodule
`default_nettype wire

// ----- rtl/core/rcc_bin_mem.sv -----
`default_nettype none
module rcc_bin_mem #(
    parameter int DEPTH = rcc_pkg::DEGREE_BINS_DEF,
    parameter int AW    = $clog2(rcc_pkg::DEGREE_BINS_DEF)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rd_en,
    input  wire logic [AW-1:0]             i_rd_addr,
    output logic      [rcc_pkg::NODE_W-1:0] o_rd_node,
    output logic      [rcc_pkg::ARC_W-1:0]  o_rd_arc,
    input  wire logic                      i_wr_node_en,
    input  wire logic                      i_wr_arc_en,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [rcc_pkg::NODE_W-1:0] i_wr_node,
    input  wire logic [rcc_pkg::ARC_W-1:0]  i_wr_arc
);
    import rcc_pkg::*;

    logic [NODE_W-1:0] r_node_mem [DEPTH];
    logic [ARC_W-1:0]  r_arc_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_node_en) begin
            r_node_mem[i_wr_addr] <= i_wr_node;
        end
        if (i_wr_arc_en) begin
            r_arc_mem[i_wr_addr] <= i_wr_arc;
        end
        if (i_rd_en) begin
            o_rd_node <= r_node_mem[i_rd_addr];
            o_rd_arc  <= r_arc_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/rcc_coef.sv -----
`default_nettype none
module rcc_coef #(
    parameter int FRACTION_BITS = rcc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rcc_pkg::NODE_W-1:0] i_n,
    input  wire logic [rcc_pkg::ARC_W-1:0]  i_arcs,
    output logic                            o_done,
    output logic      [rcc_pkg::COEF_W-1:0] o_coef
);
    import rcc_pkg::*;

    localparam int FW = FRACTION_BITS + 1;
    localparam int CW = $clog2(FRACTION_BITS + 1);
    localparam logic [63:0] CAP_L = (FRACTION_BITS >= 16) ? 64'h1FFFF :
                                    ((64'd1 << (FRACTION_BITS + 1)) - 64'd1);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MUL  = 3'd1;
    localparam logic [2:0] C_CHK  = 3'd2;
    localparam logic [2:0] C_REM  = 3'd3;
    localparam logic [2:0] C_ITER = 3'd4;
    localparam logic [2:0] C_DONE = 3'd5;

    logic [2:0]        r_state;
    logic [NODE_W-1:0] r_n;
    logic [ARC_W-1:0]  r_arcs;
    logic [63:0]       r_pairs;
    logic [63:0]       r_rem;
    logic [FW-1:0]     r_frac;
    logic [CW-1:0]     r_cnt;
    logic              r_capped;

    logic [NODE_W-1:0] nm1;
    logic [64:0]       rem2;
    logic              take;
    logic              sat;

    assign nm1  = r_n - 32'd1;
    assign rem2 = {r_rem, 1'b0};
    assign take = rem2 >= {1'b0, r_pairs};
    assign sat  = r_capped || ({{(64 - FW){1'b0}}, r_frac} > CAP_L);

    assign o_done = (r_state == C_DONE);
    assign o_coef = COEF_W'(sat ? CAP_L : {{(64 - FW){1'b0}}, r_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_n;
                        r_arcs  <= i_arcs;
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_pairs <= {32'd0, r_n} * {32'd0, nm1};
                    r_state <= C_CHK;
                end
                C_CHK: begin
                    // two or more arcs per pair saturates outright
                    if ({25'd0, r_arcs} >= {r_pairs, 1'b0}) begin
                        r_capped <= 1'b1;
                        r_state  <= C_DONE;
                    end else begin
                        r_capped <= 1'b0;
                        r_state  <= C_REM;
                    end
                end
                C_REM: begin
                    if ({24'd0, r_arcs} >= r_pairs) begin
                        r_rem  <= {24'd0, r_arcs} - r_pairs;
                        r_frac <= FW'(1);
                    end else begin
                        r_rem  <= {24'd0, r_arcs};
                        r_frac <= '0;
                    end
                    r_cnt   <= CW'(FRACTION_BITS);
                    r_state <= C_ITER;
                end
                C_ITER: begin
                    if (take) begin
                        r_rem <= 64'(rem2 - {1'b0, r_pairs});
                    end else begin
                        r_rem <= rem2[63:0];
                    end
                    r_frac <= {r_frac[FW-2:0], take};
                    r_cnt  <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= C_DONE;
                    end
                end
                C_DONE: begin
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- bench/rich_club_coefficient_engine_core_test.sv -----
`timescale 1ns / 1ps
module rich_club_coefficient_engine_core_test;
    import rcc_pkg::*;

    localparam int  BINS          = 1024;
    localparam int  FRAC          = 16;
    localparam int  TARGET_ITEMS  = 1550;
    localparam int  CYCLE_LIMIT   = 2000000;
    localparam int  DRAIN_CYCLES  = 60;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam longint unsigned NODE_CAP = 64'hFFFF_FFFF;
    localparam longint unsigned ARC_CAP  = 64'hFF_FFFF_FFFF;
    localparam longint unsigned COEF_CAP = 64'h1_FFFF;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [15:0]     in_arcs;
        logic [15:0]     out_arcs;
        logic [16:0]     src_deg;
        logic [16:0]     tgt_deg;
        logic            self_loop;
        logic [9:0]      thr;
        bit              wait_drain;   // hold until every result is back
    } t_graph_item;

    typedef struct {
        logic        kind;
        logic        valid_res;
        logic [31:0] club_nodes;
        logic [39:0] club_arcs;
        logic [16:0] coef;
        logic [10:0] useful;
        logic [9:0]  largest;
        logic        ovf;
    } t_club_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [OP_W-1:0]        i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    rich_club_coefficient_engine_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_graph_item  pending_items[$];
    t_club_result expected_results[$];
    int           fail_count = 0;
    int           cycle_count = 0;

    // Shadow histograms and flags of the engine
    longint unsigned node_hist[BINS];
    longint unsigned arc_hist[BINS];
    logic [9:0]      top_degree;
    bit              summed;
    bit              ovf_sticky;

    task automatic wipe_histograms();
        for (int t = 0; t < BINS; t++) begin
            node_hist[t] = 0;
            arc_hist[t]  = 0;
        end
        top_degree = '0;
        summed     = 1'b0;
        ovf_sticky = 1'b0;
    endtask

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                                longint unsigned cap);
        if (a > cap - b) begin
            ovf_sticky = 1'b1;
            return cap;
        end
        return a + b;
    endfunction

    function automatic int unsigned fold_degree(longint unsigned d);
        if (d > BINS - 1) begin
            ovf_sticky = 1'b1;
            return BINS - 1;
        end
        return 32'(d);
    endfunction

    // floor(arcs * 2^FRAC / pairs), restoring division, saturated to the Q1.16 maximum
    function automatic longint unsigned q16_ratio(longint unsigned arcs,
                                                  longint unsigned pairs);
        longint unsigned whole, rem, frac;
        whole = arcs / pairs;
        rem   = arcs % pairs;
        frac  = 0;
        if (whole >= 2) return COEF_CAP;
        for (int i = 0; i < FRAC; i++) begin
            frac = frac << 1;
            if (rem >= pairs - rem) begin
                rem  = rem - (pairs - rem);
                frac = frac | 1;
            end else begin
                rem = rem + rem;
            end
        end
        frac = frac | (whole << FRAC);
        return (frac > COEF_CAP) ? COEF_CAP : frac;
    endfunction

    task automatic apply_item(t_graph_item it);
        t_club_result    r;
        int unsigned     d;
        longint unsigned run_n, run_a, old_n, old_a, n, a, lo;
        int              useful;
        r = '{default: '0};
        case (it.op)
            OP_CLEAR: wipe_histograms();
            OP_NODE: if (!summed) begin
                d = fold_degree(longint'(it.in_arcs) + longint'(it.out_arcs));
                node_hist[d] = add_sat(node_hist[d], 1, NODE_CAP);
                if (d > top_degree) top_degree = d[9:0];
            end
            OP_ARC: if (!summed && !it.self_loop) begin
                lo = longint'((it.src_deg < it.tgt_deg) ? it.src_deg : it.tgt_deg);
                d  = fold_degree(lo);
                arc_hist[d] = add_sat(arc_hist[d], 1, ARC_CAP);
            end
            OP_FIN: begin
                if (!summed) begin
                    // suffix sums, strictly above each threshold
                    run_n = 0;
                    run_a = 0;
                    for (int t = BINS - 1; t >= 0; t--) begin
                        old_n = node_hist[t];
                        old_a = arc_hist[t];
                        node_hist[t] = run_n;
                        arc_hist[t]  = run_a;
                        run_n = add_sat(run_n, old_n, NODE_CAP);
                        run_a = add_sat(run_a, old_a, ARC_CAP);
                    end
                    summed = 1'b1;
                end
                useful = 0;
                for (int t = 0; t < BINS; t++)
                    if (node_hist[t] >= 2) useful++;
                r.kind    = KIND_FIN;
                r.useful  = useful[10:0];
                r.largest = top_degree;
                r.ovf     = ovf_sticky;
                expected_results.insert(expected_results.size(), r);
            end
            OP_QUERY: begin
                n = 0;
                a = 0;
                if (summed) begin
                    n = node_hist[it.thr];
                    a = arc_hist[it.thr];
                end
                r.kind = KIND_QUERY;
                if (n >= 2) begin
                    r.valid_res = 1'b1;
                    r.coef      = 17'(q16_ratio(a, n * (n - 1)));
                end
                r.club_nodes = n[31:0];
                r.club_arcs  = a[39:0];
                r.ovf        = ovf_sticky;
                expected_results.insert(expected_results.size(), r);
            end
            default: ;  // spare opcodes do nothing
        endcase
    endtask

    // ---------------- stimulus helpers ----------------
    function automatic t_graph_item make_item(logic [OP_W-1:0] op);
        t_graph_item it;
        it.op         = op;
        it.in_arcs    = 16'($urandom);
        it.out_arcs   = 16'($urandom);
        it.src_deg    = 17'($urandom_range(0, 131070));
        it.tgt_deg    = 17'($urandom_range(0, 131070));
        it.self_loop  = 1'($urandom);
        it.thr        = 10'($urandom);
        it.wait_drain = 1'b0;
        // mostly keep degrees in the low bins so clubs have several members
        if ($urandom_range(0, 9) != 0) begin
            it.in_arcs  = 16'($urandom_range(0, 15));
            it.out_arcs = 16'($urandom_range(0, 15));
            it.src_deg  = 17'($urandom_range(0, 30));
            it.tgt_deg  = 17'($urandom_range(0, 30));
            it.thr      = 10'($urandom_range(0, 35));
            it.self_loop = ($urandom_range(0, 7) == 0);
        end
        return it;
    endfunction

    task automatic push_op(logic [OP_W-1:0] op);
        pending_items.insert(pending_items.size(), make_item(op));
    endtask

    task automatic push_node(int ia, int oa);
        t_graph_item it;
        it = make_item(OP_NODE);
        it.in_arcs  = 16'(ia);
        it.out_arcs = 16'(oa);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_arc(int s, int g, bit loop);
        t_graph_item it;
        it = make_item(OP_ARC);
        it.src_deg   = 17'(s);
        it.tgt_deg   = 17'(g);
        it.self_loop = loop;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_query(int th);
        t_graph_item it;
        it = make_item(OP_QUERY);
        it.thr = 10'(th);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic build_stimulus();
        int n_build, n_query;
        t_graph_item it;
        // directed: extremes, self-loops, clamps, order corner cases
        push_query(3);                  // query before finalize
        push_node(0, 0);
        push_node(2, 3);
        push_node(3, 2);
        push_node(65535, 65535);        // clamps to top bin, sets overflow
        push_arc(5, 9, 1'b0);
        push_arc(9, 5, 1'b0);
        push_arc(5, 5, 1'b1);           // self-loop ignored
        push_arc(131070, 131070, 1'b0); // clamp
        push_arc(0, 131070, 1'b0);
        push_op(OP_FIN);
        push_op(OP_FIN);                // repeated finalize
        push_node(4, 4);                // ignored after finalize
        push_query(0);
        push_query(4);
        push_query(1023);
        push_query(1022);
        push_op(OP_SPARE_FIRST);
        push_op(OP_SPARE_FIRST + 3'd1);
        push_op(OP_SPARE_FIRST + 3'd2);
        push_op(OP_CLEAR);
        push_node(1, 1);
        push_node(1, 1);
        push_op(OP_FIN);
        push_query(1);

        // random graph sessions: build, finalize, ask
        while (pending_items.size() < TARGET_ITEMS) begin
            push_op(OP_CLEAR);
            n_build = $urandom_range(8, 60);
            for (int i = 0; i < n_build; i++) begin
                case ($urandom_range(0, 19))
                    0:       push_op(OP_QUERY);
                    1:       push_op(OP_SPARE_FIRST + 3'($urandom_range(0, 2)));
                    default: push_op(($urandom_range(0, 1) != 0) ? OP_NODE : OP_ARC);
                endcase
            end
            push_op(OP_FIN);
            n_query = $urandom_range(2, 12);
            for (int i = 0; i < n_query; i++) begin
                case ($urandom_range(0, 11))
                    0:       push_op(OP_FIN);
                    1:       push_op(OP_NODE);
                    2:       push_op(OP_ARC);
                    default: push_op(OP_QUERY);
                endcase
            end
        end
        // sender waits for a full drain once, midway
        it = pending_items[TARGET_ITEMS / 2];
        it.wait_drain = 1'b1;
        pending_items[TARGET_ITEMS / 2] = it;
    endtask

    // ---------------- driver ----------------
    t_graph_item cur_item;
    int          send_gap = 0;
    bit          send_burst = 1'b0;
    bit          send_fire;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            send_fire = i_s_axis_tvalid && o_s_axis_tready;
            if (send_fire) begin
                apply_item(cur_item);
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end
            if (!i_s_axis_tvalid || send_fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].wait_drain && expected_results.size() > 0)) begin
                    cur_item = pending_items.pop_front();
                    i_s_axis_tdata <= {3'b000, cur_item.thr, cur_item.self_loop,
                                       cur_item.tgt_deg, cur_item.src_deg,
                                       cur_item.out_arcs, cur_item.in_arcs};
                    i_s_axis_tuser  <= cur_item.op;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int           recv_gap = 0;
    bit           recv_burst = 1'b0;
    t_club_result want;
    t_club_result got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind       = o_m_axis_tuser;
                got.valid_res  = o_m_axis_tdata[0];
                got.club_nodes = o_m_axis_tdata[32:1];
                got.club_arcs  = o_m_axis_tdata[72:33];
                got.coef       = o_m_axis_tdata[89:73];
                got.useful     = o_m_axis_tdata[100:90];
                got.largest    = o_m_axis_tdata[110:101];
                got.ovf        = o_m_axis_tdata[111];
                if (expected_results.size() == 0) begin
                    $error("unexpected result item, kind %0d", got.kind);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0d, got %0d", want.valid_res,
                               got.valid_res);
                        fail_count++;
                    end
                    if (got.club_nodes !== want.club_nodes) begin
                        $error("club_nodes: expected %0d, got %0d", want.club_nodes,
                               got.club_nodes);
                        fail_count++;
                    end
                    if (got.club_arcs !== want.club_arcs) begin
                        $error("club_arc_count: expected %0d, got %0d", want.club_arcs,
                               got.club_arcs);
                        fail_count++;
                    end
                    if (got.coef !== want.coef) begin
                        $error("coefficient_q16: expected %0d, got %0d", want.coef,
                               got.coef);
                        fail_count++;
                    end
                    if (got.useful !== want.useful) begin
                        $error("useful_thresholds: expected %0d, got %0d", want.useful,
                               got.useful);
                        fail_count++;
                    end
                    if (got.largest !== want.largest) begin
                        $error("largest_degree: expected %0d, got %0d", want.largest,
                               got.largest);
                        fail_count++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 6);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rich_club_coefficient_engine_core_test NOT OK");
            $finish;
        end
    end

    initial begin
        wipe_histograms();
        build_stimulus();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !i_s_axis_tvalid &&
              expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("rich_club_coefficient_engine_core_test OK");
        end else begin
            $display("rich_club_coefficient_engine_core_test NOT OK");
        end
        $finish;
    end
endmodule
